>>> rtl/dsv_pkg.sv
// Shared types, constants and the month length table for the date string checker.
package dsv_pkg;

  localparam int DATE_LEN = 10;
  localparam int POS_SAT = 11;
  localparam int MIN_YEAR = 1900;
  localparam int MONTHS = 12;
  localparam int LEAP_FEB_DAYS = 29;
  localparam int MONTH_FEB = 2;
  localparam int YEAR_W = 14;
  localparam int DM_W = 7;
  localparam int POS_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // one finished string, handed from the front to the back
  typedef struct packed {
    logic              fmt_ok;
    logic              leap;
    logic [DM_W-1:0]   day;
    logic [DM_W-1:0]   month;
    logic [YEAR_W-1:0] year;
  } rec_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [4:0] month_len(input logic [DM_W-1:0] month);
    logic [4:0] len;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
      7'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/dsv_front.sv
// Front end: takes characters, checks the form, gathers day, month, year and leap flag.
module dsv_front import dsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       push,
  output rec_t       push_rec
);

  logic [POS_W-1:0]  position, position_next;
  logic              form_ok, form_ok_next;
  logic [DM_W-1:0]   day_value, day_value_next;
  logic [DM_W-1:0]   month_value, month_value_next;
  logic [YEAR_W-1:0] year_value, year_value_next;
  logic [3:0]        ydig [4];
  logic [3:0]        ydig_next [4];

  logic [POS_W-1:0]  pos_upd;
  logic              form_upd;
  logic [DM_W-1:0]   day_upd, month_upd;
  logic [YEAR_W-1:0] year_upd;
  logic              digit;
  logic [3:0]        dv;
  logic              yy_zero;
  logic [4:0]        yy_mod, cc_mod;

  assign digit = (ch inside {[CHAR_ZERO:CHAR_NINE]});
  assign dv    = digit ? ch[3:0] : 4'd0;

  always_comb begin
    form_upd  = form_ok;
    day_upd   = day_value;
    month_upd = month_value;
    year_upd  = year_value;
    for (int i = 0; i < 4; i++) begin
      ydig_next[i] = ydig[i];
    end
    case (position)
      4'd0, 4'd1: begin
        if (digit) day_upd = DM_W'({day_value, 3'b000} + {day_value, 1'b0} + DM_W'(dv));
        else form_upd = 1'b0;
      end
      4'd2, 4'd5: begin
        if (ch != CHAR_SLASH) form_upd = 1'b0;
      end
      4'd3, 4'd4: begin
        if (digit) month_upd = DM_W'({month_value, 3'b000} + {month_value, 1'b0} + DM_W'(dv));
        else form_upd = 1'b0;
      end
      4'd6, 4'd7, 4'd8, 4'd9: begin
        if (digit) begin
          year_upd = YEAR_W'({year_value, 3'b000} + {year_value, 1'b0} + YEAR_W'(dv));
          ydig_next[3] = ydig[2];
          ydig_next[2] = ydig[1];
          ydig_next[1] = ydig[0];
          ydig_next[0] = dv;
        end else begin
          form_upd = 1'b0;
        end
      end
      default: form_upd = 1'b0;
    endcase
    pos_upd = (position < POS_W'(POS_SAT)) ? position + POS_W'(1) : POS_W'(POS_SAT);
  end

  // leap: yy % 4 == 0 and yy != 0, or yy == 0 and century % 4 == 0
  assign yy_zero = (ydig_next[1] == 4'd0) && (ydig_next[0] == 4'd0);
  assign yy_mod  = {ydig_next[1], 1'b0} + 5'(ydig_next[0]);
  assign cc_mod  = {ydig_next[3], 1'b0} + 5'(ydig_next[2]);

  always_comb begin
    push_rec.fmt_ok = form_upd && (pos_upd == POS_W'(DATE_LEN));
    push_rec.leap   = yy_zero ? (cc_mod[1:0] == 2'd0) : (yy_mod[1:0] == 2'd0);
    push_rec.day    = day_upd;
    push_rec.month  = month_upd;
    push_rec.year   = year_upd;
  end

  assign push = accept && last;

  always_comb begin
    position_next    = position;
    form_ok_next     = form_ok;
    day_value_next   = day_value;
    month_value_next = month_value;
    year_value_next  = year_value;
    if (accept) begin
      if (last) begin
        position_next    = '0;
        form_ok_next     = 1'b1;
        day_value_next   = '0;
        month_value_next = '0;
        year_value_next  = '0;
      end else begin
        position_next    = pos_upd;
        form_ok_next     = form_upd;
        day_value_next   = day_upd;
        month_value_next = month_upd;
        year_value_next  = year_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      form_ok     <= 1'b1;
      day_value   <= '0;
      month_value <= '0;
      year_value  <= '0;
    end else begin
      position    <= position_next;
      form_ok     <= form_ok_next;
      day_value   <= day_value_next;
      month_value <= month_value_next;
      year_value  <= year_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        ydig[i] <= ydig_next[i];
      end
    end
  end

endmodule

>>> rtl/dsv_queue.sv
// Two-entry queue of finished strings between front and back.
module dsv_queue import dsv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rec_t      push_rec,
  input  logic      pop,
  output rec_t      head,
  output q_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  rec_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign status.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10: count <= count + (PTR_W+1)'(1);
        2'b01: count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/dsv_back.sv
// Back end: calendar check of one queued string and the result register.
module dsv_back import dsv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [YEAR_W-1:0] current_year,
  input  rec_t              head,
  input  logic              q_empty,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              valid_res
);

  logic       year_ok, month_ok, day_ok, ok;
  logic [4:0] len;

  assign year_ok  = (head.year >= YEAR_W'(MIN_YEAR)) && (head.year <= current_year);
  assign month_ok = (head.month >= DM_W'(1)) && (head.month <= DM_W'(MONTHS));
  assign len = (head.month == DM_W'(MONTH_FEB) && head.leap) ? 5'(LEAP_FEB_DAYS)
                                                             : month_len(head.month);
  assign day_ok = (head.day >= DM_W'(1)) && (head.day <= DM_W'(len));
  assign ok     = head.fmt_ok && year_ok && month_ok && day_ok;

  assign pop = !q_empty && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) valid_res <= ok;
  end

endmodule

>>> rtl/date_string_validator.sv
// Top level of the DD/MM/YYYY date string checker.
// Characters enter one per cycle on the item channel; last marks the end of a
// string. One transfer on the result channel follows each string, carrying
// valid_res, once the string has passed through the two-entry string queue
// and then the result register. The character input stalls only while that
// queue is full, so while the result channel does not stall the sustained
// rate is one character per cycle. current_year is written through
// cfg_wr_en/cfg_wr_data and resets to 2025.
module date_string_validator import dsv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [YEAR_W-1:0] cfg_wr_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [7:0]        ch,
  input  logic              last,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              valid_res
);

  logic [YEAR_W-1:0] current_year;
  logic              accept, push, pop;
  rec_t              push_rec, head;
  q_status_t         q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year <= YEAR_W'(2025);
    end else if (cfg_wr_en) begin
      current_year <= cfg_wr_data;
    end
  end

  assign item_stall = q_status.full;
  assign accept     = item_valid && !q_status.full;

  dsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ch       (ch),
    .last     (last),
    .push     (push),
    .push_rec (push_rec)
  );

  dsv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  dsv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .current_year (current_year),
    .head         (head),
    .q_empty      (q_status.empty),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .valid_res    (valid_res)
  );

endmodule

>>> test/tb.sv
// Self-checking testbench for date_string_validator: streams DD/MM/YYYY strings and checks each verdict.
module tb import dsv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] c;
    logic       l;
  } char_t;

  localparam int PHASES = 6;
  localparam int PHASE_CHARS = 125;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [YEAR_W-1:0] cfg_wr_data = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [7:0]        ch = 8'h00;
  logic              last = 1'b0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic              valid_res;

  date_string_validator u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .ch          (ch),
    .last        (last),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .valid_res   (valid_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the block's string state and year limit
  logic [POS_W-1:0]  st_pos = '0;
  logic              st_form = 1'b1;
  logic [DM_W-1:0]   st_day = '0;
  logic [DM_W-1:0]   st_month = '0;
  logic [YEAR_W-1:0] st_year = '0;
  logic [YEAR_W-1:0] lim_year = 14'd2025;

  char_t      char_q[$];
  logic       verdict_q[$];
  logic [7:0] txt[$];
  char_t      nxt;
  logic       want;

  int send_idle = 0;
  int recv_stall = 0;
  int phase_chars = 0;
  int errors = 0;
  int n_chars = 0;
  int n_strings = 0;
  int n_dates = 0;
  int idle_cnt = 0;

  function automatic int days_in(input int m, input int y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      MONTH_FEB: return leap ? LEAP_FEB_DAYS : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic logic date_real(input logic [DM_W-1:0] d, input logic [DM_W-1:0] m,
                                     input logic [YEAR_W-1:0] y);
    if (y < MIN_YEAR || y > lim_year) return 1'b0;
    if (m < 1 || m > MONTHS) return 1'b0;
    return (d >= 1) && (d <= days_in(int'(m), int'(y)));
  endfunction

  function automatic void track_char(input logic [7:0] c, input logic l);
    logic             is_dig;
    logic [3:0]       dv;
    logic [POS_W-1:0] idx;
    idx = st_pos;
    is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    dv = is_dig ? 4'(c - CHAR_ZERO) : 4'd0;
    if (idx >= DATE_LEN) begin
      st_form = 1'b0;
    end else if (idx == 2 || idx == 5) begin
      if (c != CHAR_SLASH) st_form = 1'b0;
    end else if (!is_dig) begin
      st_form = 1'b0;
    end else if (idx < 2) begin
      st_day = st_day * 7'd10 + 7'(dv);
    end else if (idx < 5) begin
      st_month = st_month * 7'd10 + 7'(dv);
    end else begin
      st_year = st_year * 14'd10 + 14'(dv);
    end
    st_pos = (idx + 1 < POS_SAT) ? idx + 4'd1 : 4'(POS_SAT);
    if (l) begin
      verdict_q.push_back(st_form && (st_pos == DATE_LEN) && date_real(st_day, st_month, st_year));
      st_pos = '0;
      st_form = 1'b1;
      st_day = '0;
      st_month = '0;
      st_year = '0;
    end
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic l);
    char_t e;
    e.c = c;
    e.l = l;
    char_q.push_back(e);
    phase_chars++;
  endfunction

  function automatic void flush_txt();
    for (int i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
    txt.delete();
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    flush_txt();
  endfunction

  function automatic void date_txt(input int d, input int m, input int y);
    txt.delete();
    txt.push_back(CHAR_ZERO + 8'(d / 10));
    txt.push_back(CHAR_ZERO + 8'(d % 10));
    txt.push_back(CHAR_SLASH);
    txt.push_back(CHAR_ZERO + 8'(m / 10));
    txt.push_back(CHAR_ZERO + 8'(m % 10));
    txt.push_back(CHAR_SLASH);
    txt.push_back(CHAR_ZERO + 8'(y / 1000));
    txt.push_back(CHAR_ZERO + 8'((y / 100) % 10));
    txt.push_back(CHAR_ZERO + 8'((y / 10) % 10));
    txt.push_back(CHAR_ZERO + 8'(y % 10));
  endfunction

  function automatic int pick_year();
    int hi;
    int leaps[5] = '{2000, 2100, 2400, 1904, 2024};
    hi = (lim_year < MIN_YEAR) ? 9999 : ((lim_year > 9999) ? 9999 : int'(lim_year));
    case ($urandom_range(0, 7))
      0: return MIN_YEAR;
      1: return MIN_YEAR - 1;
      2: return hi;
      3: return (hi < 9999) ? hi + 1 : 9999;
      4: return leaps[$urandom_range(0, 4)];
      default: return $urandom_range(MIN_YEAR, hi);
    endcase
  endfunction

  function automatic void gen_string();
    int r;
    int d;
    int m;
    int y;
    int len;
    int n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      y = pick_year();
      n = $urandom_range(0, 99);
      if (n < 20) m = MONTH_FEB;
      else if (n < 88) m = $urandom_range(1, MONTHS);
      else if (n < 92) m = 0;
      else if (n < 96) m = MONTHS + 1;
      else m = $urandom_range(0, 99);
      if (m >= 1 && m <= MONTHS) begin
        len = days_in(m, y);
        case ($urandom_range(0, 9))
          0: d = len;
          1: d = len + 1;
          2: d = 0;
          3: d = $urandom_range(0, 99);
          default: d = $urandom_range(1, len);
        endcase
      end else begin
        d = $urandom_range(1, 31);
      end
      date_txt(d, m, y);
    end else if (r < 80) begin
      date_txt($urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 9999));
    end else if (r < 90) begin
      date_txt($urandom_range(1, 28), $urandom_range(1, MONTHS), $urandom_range(MIN_YEAR, 2025));
      case ($urandom_range(0, 2))
        0: txt[$urandom_range(0, DATE_LEN - 1)] = 8'($urandom_range(0, 255));
        1: begin
          n = $urandom_range(1, DATE_LEN - 1);
          while (txt.size() > n) void'(txt.pop_back());
        end
        default: begin
          n = $urandom_range(1, 5);
          repeat (n) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
    end else begin
      txt.delete();
      n = $urandom_range(1, 14);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end
    flush_txt();
  endfunction

  task automatic write_year(input logic [YEAR_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lim_year = v;
  endtask

  task automatic drain();
    while (char_q.size() != 0 || item_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        track_char(ch, last);
        n_chars++;
      end
      if (!item_valid || !item_stall) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = char_q.pop_front();
          ch <= nxt.c;
          last <= nxt.l;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall);
      if (res_valid && !res_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got valid_res=%0b",
                   $time, valid_res);
        end else begin
          want = verdict_q.pop_front();
          n_strings++;
          if (valid_res === 1'b1) n_dates++;
          if (valid_res !== want) begin
            errors++;
            $display("%0t: valid_res mismatch, expected %0b, got %0b", $time, want, valid_res);
          end
        end
      end
    end
  end

  // watchdog: no transfer for too long while work is pending
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
        !(char_q.size() != 0 || item_valid || verdict_q.size() != 0)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transfer in %0d cycles", $time, IDLE_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int year_plan[PHASES];
    int send_plan[4];
    int recv_plan[4];
    send_plan = '{0, 77, 0, 8};
    recv_plan = '{0, 0, 77, 8};
    year_plan = '{2025, 16383, 1900, 1899, 9999, 0};
    year_plan[PHASES - 1] = $urandom_range(1950, 2100);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_year(14'(year_plan[p]));
      send_idle = send_plan[p % 4];
      recv_stall = recv_plan[p % 4];
      phase_chars = 0;
      if (p == 0) begin
        add_text("29/02/2000");
        add_text("31/12/20251");
        add_text("/");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
      end
      while (phase_chars < PHASE_CHARS) gen_string();
      drain();
    end
    $display("covered %0d characters in %0d strings, %0d real dates and %0d rejected",
             n_chars, n_strings, n_dates, n_strings - n_dates);
    $display("year limits 2025, 16383, 1900, 1899, 9999 and %0d, under four idle mixes",
             year_plan[PHASES - 1]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dsv_pkg.sv
rtl/dsv_front.sv
rtl/dsv_queue.sv
rtl/dsv_back.sv
rtl/date_string_validator.sv
test/tb.sv
